@@ hw/rtl/cpqm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cpqm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 10;
    localparam int MAX_LENGTH  = 255;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // register indexes on the configuration port
    localparam logic [0:0] REG_HIGH_CODE = 1'b0;
    localparam logic [0:0] REG_LOW_CODE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEN  = 3'd1,
        ST_BAD_SUM  = 3'd2,
        ST_BAD_PRIO = 3'd3,
        ST_FULL     = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_BAD_DEQ  = 3'd6
    } status_t;

    typedef struct packed {
        logic                   push;
        logic                   pop;
        logic [HANDLE_BITS-1:0] push_data;
    } fifo_ctrl_t;

    typedef struct packed {
        logic                empty;
        logic                full;
        logic [CNT_BITS-1:0] count;
    } fifo_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/checksum_priority_queue_manager_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// two-priority output queue manager with xor packet checksum
// s_axis: one word per packet byte (tuser = 0) or dequeue request (tuser = 1);
//   tlast marks the final byte of a packet, header fields are taken from that word
// m_axis: one word per last byte and per dequeue request, none for other bytes;
//   tuser = 0 enqueue outcome, 1 dequeue outcome
// cfg: register 0 = high priority code, register 1 = low priority code;
//   always ready, write only while no word is in flight
// flow: a word is held in the input register on entry, then checked and applied
//   to the queues as it leaves it; its outcome is registered in the result
//   register and driven on m_axis from there
// throughput: one word per cycle unless an outcome word waits on m_tready, set by
//   the combinational checksum/compare path and one queue pointer update per word
// reset: accumulator, byte count, queue pointers and counts go to zero, codes
//   go to 0 and 1; queue storage keeps no reset value
// stall: while m_tready is low the outcome word holds; data bytes that give no
//   outcome keep flowing, a word that gives one waits in the input register and
//   s_tready stays low until the outcome leaves
module checksum_priority_queue_manager_top (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // data_byte, dest_addr, src_addr, priority_req, length, expected_checksum,
    // packet_handle, deq_priority, zero fill
    input  wire logic [71:0] s_tdata,
    input  wire logic        s_tlast,   // last_byte
    input  wire logic [0:0]  s_tuser,   // mode

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status, queue_select, handle_out, computed_checksum, zero fill
    output logic [23:0]      m_tdata,
    output logic [0:0]       m_tuser,   // kind

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int HB = cpqm_pkg::HANDLE_BITS;

    // input register
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_mode_reg;
    logic          s1_last_reg;
    logic [7:0]    s1_data_reg;
    logic [7:0]    s1_dest_reg;
    logic [7:0]    s1_src_reg;
    logic [7:0]    s1_prio_reg;
    logic [7:0]    s1_len_reg;
    logic [7:0]    s1_exp_reg;
    logic [HB-1:0] s1_handle_reg;
    logic [7:0]    s1_deq_reg;

    logic [7:0]    high_code_reg;
    logic [7:0]    low_code_reg;
    logic [7:0]    acc_reg, acc_next;
    logic [7:0]    cnt_reg, cnt_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_kind_reg, out_kind_next;
    cpqm_pkg::status_t     out_status_reg, out_status_next;
    logic                  out_qsel_reg, out_qsel_next;
    logic [HB-1:0]         out_handle_reg, out_handle_next;
    logic [7:0]            out_csum_reg, out_csum_next;
    logic                  out_deq_ok_reg, out_deq_ok_next;

    cpqm_pkg::fifo_ctrl_t  high_ctrl, low_ctrl;
    cpqm_pkg::fifo_stat_t  high_stat, low_stat;
    logic [HB-1:0]         high_rd_data, low_rd_data;

    logic       in_take;
    logic       produces;
    logic       fire;
    logic [7:0] acc_sum;
    logic [7:0] cnt_sat;
    logic [7:0] csum;
    logic       len_bad;

    assign produces = s1_mode_reg | s1_last_reg;
    assign fire     = s1_valid_reg & (~produces | ~out_valid_reg | m_tready);
    assign s_tready = ~s1_valid_reg | fire;
    assign in_take  = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    assign acc_sum = acc_reg ^ s1_data_reg;
    assign cnt_sat = (cnt_reg == 8'hFF) ? cnt_reg : cnt_reg + 8'd1;
    assign csum    = s1_dest_reg ^ s1_src_reg ^ s1_prio_reg ^ s1_len_reg ^ acc_sum;
    assign len_bad = (s1_len_reg == 8'd0) || (s1_len_reg > 8'(cpqm_pkg::MAX_LENGTH))
                     || (s1_len_reg != cnt_sat);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        high_ctrl       = '{push: 1'b0, pop: 1'b0, push_data: s1_handle_reg};
        low_ctrl        = '{push: 1'b0, pop: 1'b0, push_data: s1_handle_reg};
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_qsel_next   = out_qsel_reg;
        out_handle_next = out_handle_reg;
        out_csum_next   = out_csum_reg;
        out_deq_ok_next = out_deq_ok_reg;

        if (fire)
        begin
            if (!s1_mode_reg)
            begin
                if (!s1_last_reg)
                begin
                    acc_next = acc_sum;
                    cnt_next = cnt_sat;
                end
                else
                begin
                    acc_next        = '0;
                    cnt_next        = '0;
                    out_kind_next   = 1'b0;
                    out_csum_next   = csum;
                    out_qsel_next   = 1'b0;
                    out_handle_next = '0;
                    out_deq_ok_next = 1'b0;
                    out_status_next = cpqm_pkg::ST_OK;
                    priority if (len_bad)
                    begin
                        out_status_next = cpqm_pkg::ST_BAD_LEN;
                    end
                    else if (csum != s1_exp_reg)
                    begin
                        out_status_next = cpqm_pkg::ST_BAD_SUM;
                    end
                    else if (s1_prio_reg == high_code_reg)
                    begin
                        if (high_stat.full)
                        begin
                            out_status_next = cpqm_pkg::ST_FULL;
                        end
                        else
                        begin
                            high_ctrl.push  = 1'b1;
                            out_handle_next = s1_handle_reg;
                        end
                    end
                    else if (s1_prio_reg == low_code_reg)
                    begin
                        out_qsel_next = 1'b1;
                        if (low_stat.full)
                        begin
                            out_status_next = cpqm_pkg::ST_FULL;
                        end
                        else
                        begin
                            low_ctrl.push   = 1'b1;
                            out_handle_next = s1_handle_reg;
                        end
                    end
                    else
                    begin
                        out_status_next = cpqm_pkg::ST_BAD_PRIO;
                    end
                end
            end
            else
            begin
                out_kind_next   = 1'b1;
                out_csum_next   = '0;
                out_qsel_next   = 1'b0;
                out_handle_next = '0;
                out_deq_ok_next = 1'b0;
                out_status_next = cpqm_pkg::ST_OK;
                // popped handle arrives through the queue's registered read port
                priority if (s1_deq_reg == high_code_reg)
                begin
                    if (high_stat.empty)
                    begin
                        out_status_next = cpqm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        high_ctrl.pop   = 1'b1;
                        out_deq_ok_next = 1'b1;
                    end
                end
                else if (s1_deq_reg == low_code_reg)
                begin
                    out_qsel_next = 1'b1;
                    if (low_stat.empty)
                    begin
                        out_status_next = cpqm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        low_ctrl.pop    = 1'b1;
                        out_deq_ok_next = 1'b1;
                    end
                end
                else
                begin
                    out_status_next = cpqm_pkg::ST_BAD_DEQ;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && produces)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            high_code_reg  <= 8'd0;
            low_code_reg   <= 8'd1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    cpqm_pkg::REG_HIGH_CODE: high_code_reg <= cfg_data;
                    cpqm_pkg::REG_LOW_CODE:  low_code_reg  <= cfg_data;
                    default:                 high_code_reg <= high_code_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg   <= s_tuser[0];
            s1_last_reg   <= s_tlast;
            s1_data_reg   <= s_tdata[7:0];
            s1_dest_reg   <= s_tdata[15:8];
            s1_src_reg    <= s_tdata[23:16];
            s1_prio_reg   <= s_tdata[31:24];
            s1_len_reg    <= s_tdata[39:32];
            s1_exp_reg    <= s_tdata[47:40];
            s1_handle_reg <= s_tdata[48 +: HB];
            s1_deq_reg    <= s_tdata[58 +: 8];
        end
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_qsel_reg   <= out_qsel_next;
        out_handle_reg <= out_handle_next;
        out_csum_reg   <= out_csum_next;
        out_deq_ok_reg <= out_deq_ok_next;
    end

    cpqm_fifo u_high_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (high_ctrl),
        .stat    (high_stat),
        .rd_data (high_rd_data)
    );

    cpqm_fifo u_low_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (low_ctrl),
        .stat    (low_stat),
        .rd_data (low_rd_data)
    );

    logic [HB-1:0] handle_word;

    assign handle_word = out_deq_ok_reg ? (out_qsel_reg ? low_rd_data : high_rd_data)
                                        : out_handle_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_csum_reg, handle_word, out_qsel_reg, out_status_reg};

    // a packet always restarts the accumulator and byte count
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !s1_mode_reg && s1_last_reg) |=> (acc_reg == '0 && cnt_reg == '0))
    else $error("accumulator not cleared after last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (high_stat.count <= cpqm_pkg::CNT_BITS'(cpqm_pkg::QUEUE_DEPTH))
        && (low_stat.count <= cpqm_pkg::CNT_BITS'(cpqm_pkg::QUEUE_DEPTH)))
    else $error("queue count beyond depth");

    // a queue is never pushed and popped by one word
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({high_ctrl.push, high_ctrl.pop, low_ctrl.push, low_ctrl.pop}) <= 1)
    else $error("more than one queue operation in a cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(handle_word)))
    else $error("stalled result handle changed");

endmodule

`default_nettype wire

@@ hw/rtl/cpqm_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpqm_fifo (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire cpqm_pkg::fifo_ctrl_t                ctrl,
    output cpqm_pkg::fifo_stat_t                     stat,
    output logic [cpqm_pkg::HANDLE_BITS-1:0]         rd_data
);

    logic [cpqm_pkg::HANDLE_BITS-1:0] mem [cpqm_pkg::QUEUE_DEPTH];

    logic [cpqm_pkg::PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cpqm_pkg::PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cpqm_pkg::CNT_BITS-1:0]    count_reg, count_next;
    logic [cpqm_pkg::HANDLE_BITS-1:0] rd_data_reg;

    function automatic logic [cpqm_pkg::PTR_BITS-1:0] ptr_inc(
        input logic [cpqm_pkg::PTR_BITS-1:0] p
    );
        logic [cpqm_pkg::PTR_BITS-1:0] r;
        if (p == cpqm_pkg::PTR_BITS'(cpqm_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        // the caller never pushes and pops in the same cycle
        if (ctrl.push)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            count_next  = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= ctrl.push_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == cpqm_pkg::CNT_BITS'(cpqm_pkg::QUEUE_DEPTH));
    assign rd_data    = rd_data_reg;

endmodule

`default_nettype wire
